// ===== src/vkcs_pkg.sv =====
// Shared types, constants and contact debounce function for the key contact scanner.
`default_nettype none

package vkcs_pkg;

  localparam int BANK_COUNT_DEF  = 8;
  localparam int KEY_COUNT_DEF   = 61;
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int KEYS_PER_BANK = 8;
  localparam int BANK_SLOTS    = 8;
  localparam int BANK_W        = 3;
  localparam int LANE_W        = 3;
  localparam int KEY_W         = BANK_W + LANE_W;
  localparam int SLOT_COUNT    = 2 * KEYS_PER_BANK;
  localparam int SLOT_W        = 4;
  localparam int TICKS_W       = 16;
  localparam int CNT_W         = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 4'd3;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_TOUCHED  = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_TOP      = 2'd3
  } event_code_t;

  typedef enum logic [1:0] {
    PH_UP         = 2'd0,
    PH_GOING_DOWN = 2'd1,
    PH_DOWN       = 2'd2,
    PH_GOING_UP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             fire;
    logic             opened;
  } contact_res_t;

  // Events one lane found for the scanned bank: top contact, then bottom contact.
  typedef struct packed {
    logic               top_fire;
    event_code_t        top_code;
    logic [TICKS_W-1:0] top_ticks;
    logic               bot_fire;
    event_code_t        bot_code;
    logic [TICKS_W-1:0] bot_ticks;
  } lane_ev_t;

  // One debounce step of one contact.
  function automatic contact_res_t contact_step(input logic [CNT_W-1:0] cnt,
                                                input logic cur,
                                                input logic prev,
                                                input logic [CNT_W-1:0] thr);
    contact_res_t     res;
    logic [CNT_W-1:0] c;
    res.cnt    = cnt;
    res.fire   = 1'b0;
    res.opened = 1'b0;
    c          = cnt;
    if (cnt != '0) begin
      if (cur) begin
        if (cnt < CNT_MAX) begin
          c = cnt + 1'b1;
        end
        if (c >= thr) begin
          res.fire = 1'b1;
          c        = '0;
        end
        res.cnt = c;
      end else begin
        res.cnt = '0;
      end
    end else if (cur && !prev) begin
      res.cnt = {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (!cur && prev) begin
      res.fire   = 1'b1;
      res.opened = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/velocity_key_contact_scanner.sv =====
// Top level of the two-contact velocity keyboard scanner: eight key lanes and an event merge.
// Throughput: one input beat per cycle when a scan causes at most one event; a scan with
//   several events lets the next input beat in only as its last event moves into the
//   single output register, which drains one event per cycle while the output does not stall.
//   Output stall cycles add to this. Tick beats cause no events and do not hold off the next beat.
// Reset (rst, synchronous, active high): clears all contact, debounce, phase and timer state,
//   empties the event merge and sets the debounce threshold to 3.
`default_nettype none

module velocity_key_contact_scanner #(
  parameter int BANK_COUNT  = vkcs_pkg::BANK_COUNT_DEF,
  parameter int KEY_COUNT   = vkcs_pkg::KEY_COUNT_DEF,
  parameter int TIMER_WIDTH = vkcs_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_write,
  input  wire logic [vkcs_pkg::CNT_W-1:0]     cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           operation,
  input  wire logic [vkcs_pkg::BANK_W-1:0]    bank_index,
  input  wire logic [7:0]                     left_byte,
  input  wire logic [7:0]                     right_byte,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [vkcs_pkg::KEY_W-1:0]          key_index,
  output logic [1:0]                          event_code,
  output logic [vkcs_pkg::TICKS_W-1:0]        elapsed_ticks,
  output logic                                last_of_run
);

  localparam int NK = vkcs_pkg::KEYS_PER_BANK;

  logic [vkcs_pkg::CNT_W-1:0]         debounce_scans;
  logic                               accept;
  logic                               scan_en;
  logic                               tick_en;
  logic [7:0]                         top_byte;
  logic [7:0]                         bot_byte;
  vkcs_pkg::lane_ev_t [NK-1:0]        lane_ev;
  vkcs_pkg::event_code_t              code_out;

  // Debounce threshold; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= vkcs_pkg::DEBOUNCE_RESET;
    end else if (cfg_write) begin
      debounce_scans <= cfg_data;
    end
  end

  // A beat is taken whenever the merge can hold a fresh scan's events.
  // Scans of banks beyond the configured count change nothing.
  always_comb begin
    accept  = in_valid && !in_stall;
    tick_en = accept && (vkcs_pkg::op_t'(operation) == vkcs_pkg::OP_TICK);
    scan_en = accept && (vkcs_pkg::op_t'(operation) == vkcs_pkg::OP_SCAN) &&
              (int'(bank_index) < BANK_COUNT);
  end

  // Swap nibbles: low nibbles are top contacts, high nibbles bottom contacts,
  // left zone in the low half of each byte.
  assign top_byte = {right_byte[3:0], left_byte[3:0]};
  assign bot_byte = {right_byte[7:4], left_byte[7:4]};

  // One lane per key-in-bank; all lanes see the same bank and advance timers on a tick.
  for (genvar k = 0; k < NK; k++) begin : g_lane
    vkcs_lane #(
      .LANE        (k),
      .BANK_COUNT  (BANK_COUNT),
      .KEY_COUNT   (KEY_COUNT),
      .TIMER_WIDTH (TIMER_WIDTH)
    ) u_lane (
      .clk            (clk),
      .rst            (rst),
      .scan_en        (scan_en),
      .tick_en        (tick_en),
      .bank           (bank_index),
      .top_cur        (top_byte[k]),
      .bot_cur        (bot_byte[k]),
      .debounce_scans (debounce_scans),
      .ev             (lane_ev[k])
    );
  end

  // Merge the lanes' events in key order, top before bottom, one beat per cycle unless stalled.
  vkcs_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .take          (accept),
    .bank          (bank_index),
    .lane_ev       (lane_ev),
    .busy          (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .key_index     (key_index),
    .event_code    (code_out),
    .elapsed_ticks (elapsed_ticks),
    .last_of_run   (last_of_run)
  );

  assign event_code = code_out;

endmodule

`default_nettype wire

// ===== src/vkcs_lane.sv =====
// One key lane: per-bank contact, debounce, phase and timer state for key-in-bank LANE.
`default_nettype none

module vkcs_lane #(
  parameter int LANE        = 0,
  parameter int BANK_COUNT  = vkcs_pkg::BANK_COUNT_DEF,
  parameter int KEY_COUNT   = vkcs_pkg::KEY_COUNT_DEF,
  parameter int TIMER_WIDTH = vkcs_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         scan_en,
  input  wire logic                         tick_en,
  input  wire logic [vkcs_pkg::BANK_W-1:0]  bank,
  input  wire logic                         top_cur,
  input  wire logic                         bot_cur,
  input  wire logic [vkcs_pkg::CNT_W-1:0]   debounce_scans,
  output vkcs_pkg::lane_ev_t                ev
);

  localparam int NB = vkcs_pkg::BANK_SLOTS;

  logic [NB-1:0]                prev_top;
  logic [NB-1:0]                prev_bot;
  logic [vkcs_pkg::CNT_W-1:0]   top_cnt [NB];
  logic [vkcs_pkg::CNT_W-1:0]   bot_cnt [NB];
  vkcs_pkg::phase_t             phase [NB];
  logic [TIMER_WIDTH-1:0]       timer [NB];

  logic [NB-1:0]                key_ok;
  vkcs_pkg::contact_res_t       rt;
  vkcs_pkg::contact_res_t       rb;
  logic [TIMER_WIDTH-1:0]       timer_cur;
  logic [TIMER_WIDTH-1:0]       timer_next;
  vkcs_pkg::phase_t             phase_next;
  logic [TIMER_WIDTH+15:0]      timer_wide;
  logic [vkcs_pkg::TICKS_W-1:0] timer_sat;
  logic                         live;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      key_ok[b] = (b < BANK_COUNT) && ((b + LANE * vkcs_pkg::KEYS_PER_BANK) < KEY_COUNT);
    end
  end

  always_comb begin
    rt         = vkcs_pkg::contact_step(top_cnt[bank], top_cur, prev_top[bank], debounce_scans);
    rb         = vkcs_pkg::contact_step(bot_cnt[bank], bot_cur, prev_bot[bank], debounce_scans);
    timer_cur  = timer[bank];
    timer_wide = {16'b0, timer_cur};
    timer_sat  = (|timer_wide[TIMER_WIDTH+15:16]) ? '1 : timer_wide[15:0];
    live       = scan_en && key_ok[bank];
  end

  // Top contact acts first; the bottom contact then sees the timer it left.
  always_comb begin
    phase_next   = phase[bank];
    timer_next   = timer_cur;
    ev           = '0;
    ev.top_code  = vkcs_pkg::EV_TOUCHED;
    ev.bot_code  = vkcs_pkg::EV_PRESSED;
    ev.top_fire  = live && rt.fire;
    ev.bot_fire  = live && rb.fire;
    if (rt.fire) begin
      if (rt.opened) begin
        ev.top_code  = vkcs_pkg::EV_TOP;
        ev.top_ticks = timer_sat;
        phase_next   = vkcs_pkg::PH_UP;
      end else begin
        ev.top_code  = vkcs_pkg::EV_TOUCHED;
        phase_next   = vkcs_pkg::PH_GOING_DOWN;
      end
      timer_next = '0;
    end
    if (rb.fire) begin
      if (rb.opened) begin
        ev.bot_code = vkcs_pkg::EV_RELEASED;
        phase_next  = vkcs_pkg::PH_GOING_UP;
        timer_next  = '0;
      end else begin
        ev.bot_code  = vkcs_pkg::EV_PRESSED;
        ev.bot_ticks = rt.fire ? '0 : timer_sat;
        phase_next   = vkcs_pkg::PH_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_top <= '0;
      prev_bot <= '0;
      for (int b = 0; b < NB; b++) begin
        top_cnt[b] <= '0;
        bot_cnt[b] <= '0;
        phase[b]   <= vkcs_pkg::PH_UP;
        timer[b]   <= '0;
      end
    end else begin
      if (scan_en) begin
        prev_top[bank] <= top_cur;
        prev_bot[bank] <= bot_cur;
        if (key_ok[bank]) begin
          top_cnt[bank] <= rt.cnt;
          bot_cnt[bank] <= rb.cnt;
          phase[bank]   <= phase_next;
          timer[bank]   <= timer_next;
        end
      end
      if (tick_en) begin
        for (int b = 0; b < NB; b++) begin
          if (key_ok[b] && (phase[b] == vkcs_pkg::PH_GOING_DOWN ||
                            phase[b] == vkcs_pkg::PH_GOING_UP) && (timer[b] != '1)) begin
            timer[b] <= timer[b] + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/vkcs_merge.sv =====
// Event merge: holds one scan's lane events and serializes them into the output register.
`default_nettype none

module vkcs_merge (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               take,
  input  wire logic [vkcs_pkg::BANK_W-1:0]                        bank,
  input  wire vkcs_pkg::lane_ev_t [vkcs_pkg::KEYS_PER_BANK-1:0]   lane_ev,
  output logic                                                    busy,
  output logic                                                    out_valid,
  input  wire logic                                               out_stall,
  output logic [vkcs_pkg::KEY_W-1:0]                              key_index,
  output vkcs_pkg::event_code_t                                   event_code,
  output logic [vkcs_pkg::TICKS_W-1:0]                            elapsed_ticks,
  output logic                                                    last_of_run
);

  localparam int NS = vkcs_pkg::SLOT_COUNT;

  logic [NS-1:0]                new_mask;
  vkcs_pkg::event_code_t        new_code  [NS];
  logic [vkcs_pkg::TICKS_W-1:0] new_ticks [NS];

  logic [NS-1:0]                rec_mask;
  logic [vkcs_pkg::BANK_W-1:0]  rec_bank;
  vkcs_pkg::event_code_t        rec_code  [NS];
  logic [vkcs_pkg::TICKS_W-1:0] rec_ticks [NS];

  logic [vkcs_pkg::SLOT_W-1:0]  sel;
  logic [NS-1:0]                rest;
  logic                         out_free;
  logic                         pop;

  // Slot 2k is the top contact of lane k, slot 2k+1 its bottom contact.
  always_comb begin
    for (int k = 0; k < vkcs_pkg::KEYS_PER_BANK; k++) begin
      new_mask[2*k]    = lane_ev[k].top_fire;
      new_code[2*k]    = lane_ev[k].top_code;
      new_ticks[2*k]   = lane_ev[k].top_ticks;
      new_mask[2*k+1]  = lane_ev[k].bot_fire;
      new_code[2*k+1]  = lane_ev[k].bot_code;
      new_ticks[2*k+1] = lane_ev[k].bot_ticks;
    end
  end

  always_comb begin
    sel = '0;
    for (int j = NS - 1; j >= 0; j--) begin
      if (rec_mask[j]) begin
        sel = vkcs_pkg::SLOT_W'(j);
      end
    end
    rest     = rec_mask & ~(NS'(1) << sel);
    out_free = !out_valid || !out_stall;
    pop      = (|rec_mask) && out_free;
    busy     = (|rec_mask) && !(pop && (rest == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= |rec_mask;
      end
      if (take) begin
        rec_mask <= new_mask;
      end else if (pop) begin
        rec_mask <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_bank <= bank;
      for (int j = 0; j < NS; j++) begin
        rec_code[j]  <= new_code[j];
        rec_ticks[j] <= new_ticks[j];
      end
    end
    if (pop) begin
      key_index     <= {sel[vkcs_pkg::SLOT_W-1:1], rec_bank};
      event_code    <= rec_code[sel];
      elapsed_ticks <= rec_ticks[sel];
      last_of_run   <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/key_event_sb_pkg.sv =====
// Scoreboard class that predicts and checks the key contact events of the scanner.
`timescale 1ns / 100ps

package key_event_sb_pkg;
  import vkcs_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    event_code_t        code;
    logic [TICKS_W-1:0] ticks;
    logic               last_flag;
  } key_event_t;

  class key_event_scoreboard;
    logic [CNT_W-1:0]   threshold;
    logic [15:0]        prev_contacts [BANK_SLOTS];
    logic [CNT_W-1:0]   top_count [64];
    logic [CNT_W-1:0]   bottom_count [64];
    phase_t             phase [64];
    logic [TICKS_W-1:0] key_timer [64];
    key_event_t         expected_events [$];
    int                 errors;

    function new();
      threshold = DEBOUNCE_RESET;
      errors    = 0;
      for (int b = 0; b < BANK_SLOTS; b++) begin
        prev_contacts[b] = '0;
      end
      for (int k = 0; k < 64; k++) begin
        top_count[k]    = '0;
        bottom_count[k] = '0;
        phase[k]        = PH_UP;
        key_timer[k]    = '0;
      end
    endfunction

    function void set_threshold(input logic [CNT_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Apply the phase and timer effect of one event and queue it.
    function void push_event(input int key, input event_code_t code);
      key_event_t ev;
      ev.key       = KEY_W'(key);
      ev.code      = code;
      ev.ticks     = '0;
      ev.last_flag = 1'b0;
      case (code)
        EV_TOUCHED: begin
          phase[key]     = PH_GOING_DOWN;
          key_timer[key] = '0;
        end
        EV_PRESSED: begin
          phase[key] = PH_DOWN;
          ev.ticks   = key_timer[key];
        end
        EV_RELEASED: begin
          phase[key]     = PH_GOING_UP;
          key_timer[key] = '0;
        end
        default: begin
          ev.ticks       = key_timer[key];
          phase[key]     = PH_UP;
          key_timer[key] = '0;
        end
      endcase
      expected_events.insert(expected_events.size(), ev);
    endfunction

    function void step_contact(inout logic [CNT_W-1:0] cnt, input bit cur, input bit prev,
                               input int key, input event_code_t close_ev,
                               input event_code_t open_ev);
      if (cnt != '0) begin
        if (cur) begin
          if (cnt < CNT_MAX) begin
            cnt = cnt + 1'b1;
          end
          if (cnt >= threshold) begin
            push_event(key, close_ev);
            cnt = '0;
          end
        end else begin
          cnt = '0;
        end
      end else if (cur && !prev) begin
        cnt = CNT_W'(1);
      end else if (!cur && prev) begin
        push_event(key, open_ev);
      end
    endfunction

    // Predict the events caused by one accepted input beat.
    function void note_beat(input op_t op, input logic [BANK_W-1:0] bank,
                            input logic [7:0] left, input logic [7:0] right);
      logic [7:0] top_now;
      logic [7:0] bot_now;
      logic [7:0] top_prev;
      logic [7:0] bot_prev;
      int         first;
      int         key;
      if (op == OP_TICK) begin
        for (int k = 0; k < KEY_COUNT_DEF && k < 64; k++) begin
          if ((phase[k] == PH_GOING_DOWN || phase[k] == PH_GOING_UP) &&
              key_timer[k] != {TICKS_W{1'b1}}) begin
            key_timer[k] = key_timer[k] + 1'b1;
          end
        end
        return;
      end
      if (int'(bank) >= BANK_COUNT_DEF) begin
        return;
      end
      top_now  = {right[3:0], left[3:0]};
      bot_now  = {right[7:4], left[7:4]};
      top_prev = prev_contacts[bank][7:0];
      bot_prev = prev_contacts[bank][15:8];
      first    = expected_events.size();
      for (int k = 0; k < KEYS_PER_BANK; k++) begin
        key = int'(bank) + k * KEYS_PER_BANK;
        if (key < KEY_COUNT_DEF && key < 64) begin
          step_contact(top_count[key], top_now[k], top_prev[k], key, EV_TOUCHED, EV_TOP);
          step_contact(bottom_count[key], bot_now[k], bot_prev[k], key, EV_PRESSED,
                       EV_RELEASED);
        end
      end
      prev_contacts[bank] = {bot_now, top_now};
      if (expected_events.size() > first) begin
        expected_events[expected_events.size() - 1].last_flag = 1'b1;
      end
    endfunction

    function void check_event(input logic [KEY_W-1:0] key, input logic [1:0] code,
                              input logic [TICKS_W-1:0] ticks, input logic last_flag);
      key_event_t ev;
      if (expected_events.size() == 0) begin
        $error("unexpected event beat: key_index %0d event_code %0d", key, code);
        errors++;
        return;
      end
      ev = expected_events.pop_front();
      if (ev.key !== key) begin
        $error("key_index expected %0d actual %0d", ev.key, key);
        errors++;
      end
      if (ev.code !== code) begin
        $error("event_code expected %0d actual %0d", ev.code, code);
        errors++;
      end
      if (ev.ticks !== ticks) begin
        $error("elapsed_ticks expected %0d actual %0d", ev.ticks, ticks);
        errors++;
      end
      if (ev.last_flag !== last_flag) begin
        $error("last_of_run expected %0d actual %0d", ev.last_flag, last_flag);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/velocity_key_contact_scanner_test.sv =====
// Top-level testbench of the velocity key contact scanner: stimulus, stall pattern and checks.
`timescale 1ns / 100ps

module velocity_key_contact_scanner_test;
  import vkcs_pkg::*;
  import key_event_sb_pkg::*;

  // Cycles to hold after the last expected event before touching config or ending.
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 49;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_write  = 1'b0;
  logic [CNT_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 operation  = 1'b0;
  logic [BANK_W-1:0]    bank_index = '0;
  logic [7:0]           left_byte  = '0;
  logic [7:0]           right_byte = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [KEY_W-1:0]     key_index;
  logic [1:0]           event_code;
  logic [TICKS_W-1:0]   elapsed_ticks;
  logic                 last_of_run;

  // Contact pattern the random part holds per bank; it drifts a few bits at a time.
  logic [7:0]           held_left  [BANK_SLOTS];
  logic [7:0]           held_right [BANK_SLOTS];

  key_event_scoreboard  events_sb = new();

  velocity_key_contact_scanner u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .bank_index    (bank_index),
    .left_byte     (left_byte),
    .right_byte    (right_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .key_index     (key_index),
    .event_code    (event_code),
    .elapsed_ticks (elapsed_ticks),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one beat, hold it until accepted, then predict its events.
  task automatic send_beat(input op_t op, input logic [BANK_W-1:0] bank,
                           input logic [7:0] left, input logic [7:0] right, input int gap);
    in_valid   <= 1'b1;
    operation  <= op;
    bank_index <= bank;
    left_byte  <= left;
    right_byte <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sb.note_beat(op, bank, left, right);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_scan(input logic [BANK_W-1:0] bank, input logic [7:0] left,
                           input logic [7:0] right);
    send_beat(OP_SCAN, bank, left, right, pick_gap());
  endtask

  // Tick beats carry junk in the ignored fields.
  task automatic send_tick(input int gap);
    send_beat(OP_TICK, BANK_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), gap);
  endtask

  // Drop valid, wait until every predicted event is out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (events_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    events_sb.set_threshold(value);
  endtask

  // One random beat: ticks, drifting well-formed contact patterns, holds and noise.
  task automatic random_item(input int focus_bank, input bit steady);
    int                r;
    int                gap;
    logic [BANK_W-1:0] bank;
    logic [15:0]       flips;
    r   = $urandom_range(0, 99);
    gap = steady ? 0 : pick_gap();
    if (r < 30) begin
      send_tick(gap);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        bank = BANK_W'(focus_bank);
      end else begin
        bank = BANK_W'($urandom_range(0, 7));
      end
      if (r < 42) begin
        // noise: throw a random pattern at the bank
        held_left[bank]  = 8'($urandom_range(0, 255));
        held_right[bank] = 8'($urandom_range(0, 255));
      end else if (r < 72) begin
        // drift: open or close a few contacts
        for (int i = 0; i < 16; i++) begin
          flips[i] = ($urandom_range(0, 9) == 0);
        end
        held_left[bank]  = held_left[bank] ^ flips[7:0];
        held_right[bank] = held_right[bank] ^ flips[15:8];
      end
      // otherwise hold the pattern so that debounce counts run up
      send_beat(OP_SCAN, bank, held_left[bank], held_right[bank], gap);
    end
  endtask

  // Check every event beat accepted at this edge against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      events_sb.check_event(key_index, event_code, elapsed_ticks, last_of_run);
    end
  end

  // Output stall: quiet stretches, short bursts and the odd long hold-off.
  initial begin : out_stall_gen
    int quiet;
    int busy;
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        quiet = $urandom_range(30, 120);
      end else begin
        quiet = $urandom_range(1, 4);
      end
      out_stall <= 1'b0;
      repeat (quiet) @(posedge clk);
      busy = pick_gap();
      if (busy > 0) begin
        out_stall <= 1'b1;
        repeat (busy) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int thresholds [6];
    thresholds = '{0, 15, 1, 8, 2, 0};
    thresholds[5] = $urandom_range(0, 15);
    for (int b = 0; b < BANK_SLOTS; b++) begin
      held_left[b]  = '0;
      held_right[b] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk key 0 through all four phases at the reset threshold.
    send_scan(3'd0, 8'h01, 8'h00);
    send_tick(pick_gap());
    send_tick(pick_gap());
    send_scan(3'd0, 8'h01, 8'h00);
    send_scan(3'd0, 8'h01, 8'h00);
    repeat (3) send_tick(pick_gap());
    repeat (3) send_scan(3'd0, 8'h11, 8'h00);
    send_scan(3'd0, 8'h01, 8'h00);
    send_tick(pick_gap());
    send_tick(pick_gap());
    send_scan(3'd0, 8'h00, 8'h00);

    // Close every contact of bank 4: all sixteen events in one run, then all open.
    repeat (3) send_scan(3'd4, 8'hFF, 8'hFF);
    send_scan(3'd4, 8'h00, 8'h00);

    // Bank 7 holds a key past the key count; start debounce then cancel it.
    send_scan(3'd7, 8'hFF, 8'hFF);
    send_scan(3'd7, 8'h00, 8'h00);

    // Random phases; debounce counts carry across threshold changes on purpose.
    for (int p = 0; p < 6; p++) begin
      write_threshold(CNT_W'(thresholds[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item(p, p == 3);
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    if (events_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vkcs_pkg.sv
src/vkcs_lane.sv
src/vkcs_merge.sv
src/velocity_key_contact_scanner.sv
tb/sv/key_event_sb_pkg.sv
tb/sv/velocity_key_contact_scanner_test.sv
